>>> hdl/zsl_pkg.sv
// ----------------------------------------------------------------------------
// zsl_pkg
// Shared types and constants for the zoomed sprite line scaler.
// ----------------------------------------------------------------------------
package zsl_pkg;

  // Row length limit, in source draw columns
  localparam int MAX_ROW_PIXELS = 1024;
  // Line buffer positions that exist
  localparam int LINE_LIMIT     = 1024;

  // Field widths
  localparam int WIDTH_W  = 11;   // screen_width register
  localparam int STARTX_W = 11;   // signed start x
  localparam int ZOOM_W   = 32;
  localparam int PIX_W    = 10;
  localparam int SX_W     = 10;   // screen_x
  localparam int COL_W    = 5;    // column index modulo 32
  localparam int OFF_W    = 12;   // draw offset
  localparam int POS_W    = 13;   // signed draw position

  // Offset at which a row stops taking columns
  localparam logic [OFF_W-1:0] OFFSET_LIMIT = OFF_W'(2 * MAX_ROW_PIXELS);
  localparam logic signed [POS_W-1:0] POS_LIMIT = POS_W'(LINE_LIMIT);

  // Configuration
  localparam int                ADDR_W      = 2;
  localparam logic [ADDR_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd448;

  // One result item
  typedef struct packed {
    logic [SX_W-1:0]  screen_x;
    logic [PIX_W-1:0] pixel_out;
    logic             priority_out;
    logic             last_write;
  } res_t;

  // One held input item
  typedef struct packed {
    logic                       first_column;
    logic signed [STARTX_W-1:0] start_x;
    logic [ZOOM_W-1:0]          zoom_mask;
    logic                       grow;
    logic                       priority_req;
    logic                       clear_pixel;
    logic [PIX_W-1:0]           color_value;
  } item_t;

endpackage

>>> hdl/zsl_in_if.sv
// ----------------------------------------------------------------------------
// zsl_in_if
// Source column channel: one sprite column per item.
// ----------------------------------------------------------------------------
interface zsl_in_if;
  import zsl_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       first_column;
  logic signed [STARTX_W-1:0] start_x;
  logic [ZOOM_W-1:0]          zoom_mask;
  logic                       grow;
  logic                       priority_req;
  logic                       clear_pixel;
  logic [PIX_W-1:0]           color_value;

  modport source (
    output valid, first_column, start_x, zoom_mask, grow, priority_req,
           clear_pixel, color_value,
    input  ready
  );
  modport sink (
    input  valid, first_column, start_x, zoom_mask, grow, priority_req,
           clear_pixel, color_value,
    output ready
  );
endinterface

>>> hdl/zsl_out_if.sv
// ----------------------------------------------------------------------------
// zsl_out_if
// Line buffer write channel: one pixel write per item.
// ----------------------------------------------------------------------------
interface zsl_out_if;
  import zsl_pkg::*;

  logic             valid;
  logic             ready;
  logic [SX_W-1:0]  screen_x;
  logic [PIX_W-1:0] pixel_out;
  logic             priority_out;
  logic             last_write;

  modport source (
    output valid, screen_x, pixel_out, priority_out, last_write,
    input  ready
  );
  modport sink (
    input  valid, screen_x, pixel_out, priority_out, last_write,
    output ready
  );
endinterface

>>> hdl/zoomed_sprite_line_scaler_top.sv
// ----------------------------------------------------------------------------
// zoomed_sprite_line_scaler_top
// Draws one sprite row into line buffer writes with horizontal zoom.
//
//   channel  dir  handshake      carries
//   src      in   valid/ready    one source column (latches row on first)
//   dst      out  valid/ready    one line buffer write
//   apb      in   psel/penable   screen_width register at byte 0
//
// A column is held in an input register, then decoded in one pass into a
// two-entry result buffer. A column giving no write moves on every cycle
// while the result buffer is empty; a doubled column's writes leave one at
// a time by the single write port of dst. rst is synchronous; it empties
// both stages, clears the row state and sets screen_width to 448. src.ready
// drops while the result buffer cannot take the held column's writes.
// ----------------------------------------------------------------------------
module zoomed_sprite_line_scaler_top (
  input  logic                       clk,
  input  logic                       rst,
  zsl_in_if.sink                     src,
  zsl_out_if.source                  dst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [zsl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import zsl_pkg::*;

  // Configuration register
  logic [WIDTH_W-1:0] screen_width;

  // Input stage
  item_t item;
  logic  in_full;

  // Row state
  logic [COL_W-1:0]           column_index;
  logic [OFF_W-1:0]           draw_offset;
  logic signed [POS_W-1:0]    last_draw_pos;
  logic signed [STARTX_W-1:0] row_start_x;
  logic [ZOOM_W-1:0]          row_zoom;
  logic                       row_grow;
  logic                       row_priority;
  logic                       row_finished;

  // Result buffer
  res_t       res0, res1;
  logic [1:0] res_count;

  // Decode signals
  logic                       can_load, consume, pop;
  logic [COL_W-1:0]           col_e;
  logic [OFF_W-1:0]           off_e;
  logic signed [POS_W-1:0]    lp_e;
  logic signed [STARTX_W-1:0] start_e;
  logic [ZOOM_W-1:0]          zoom_e;
  logic                       grow_e, prio_e, fin_e;
  logic                       halt, zbit;
  logic signed [POS_W-1:0]    pos, pos1, width_s;
  logic                       ok0, ok1, wr0, wr1;
  logic [OFF_W-1:0]           off_next;
  logic signed [POS_W-1:0]    lp_next;
  logic [1:0]                 n_res;
  res_t                       new0, new1;

  // APB register port
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SCREEN_WIDTH) ? {{(32-WIDTH_W){1'b0}}, screen_width} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width <= WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr == REG_SCREEN_WIDTH) begin
      screen_width <= pwdata[WIDTH_W-1:0];
    end
  end

  // Handshakes
  assign pop       = (res_count != 2'd0) && dst.ready;
  assign can_load  = (res_count == 2'd0) || (res_count == 2'd1 && dst.ready);
  assign consume   = in_full && can_load;
  assign src.ready = !in_full || consume;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (src.ready) begin
      in_full <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (src.ready && src.valid) begin
      item.first_column <= src.first_column;
      item.start_x      <= src.start_x;
      item.zoom_mask    <= src.zoom_mask;
      item.grow         <= src.grow;
      item.priority_req <= src.priority_req;
      item.clear_pixel  <= src.clear_pixel;
      item.color_value  <= src.color_value;
    end
  end

  // Effective row settings: a first column restarts the row
  always_comb begin
    if (item.first_column) begin
      col_e   = '0;
      off_e   = '0;
      lp_e    = '0;
      fin_e   = 1'b0;
      start_e = item.start_x;
      zoom_e  = item.zoom_mask;
      grow_e  = item.grow;
      prio_e  = item.priority_req;
    end else begin
      col_e   = column_index;
      off_e   = draw_offset;
      lp_e    = last_draw_pos;
      fin_e   = row_finished;
      start_e = row_start_x;
      zoom_e  = row_zoom;
      grow_e  = row_grow;
      prio_e  = row_priority;
    end
  end

  // Column decode and clipping
  assign halt    = fin_e || (off_e >= OFFSET_LIMIT);
  assign zbit    = zoom_e[col_e];
  assign pos     = POS_W'(start_e) + $signed({1'b0, off_e});
  assign pos1    = pos + 13'sd1;
  assign width_s = $signed({2'b00, screen_width});
  assign ok0     = !pos[POS_W-1] && (pos < width_s) && (pos < POS_LIMIT);
  assign ok1     = !pos1[POS_W-1] && (pos1 < width_s) && (pos1 < POS_LIMIT);

  always_comb begin
    wr0      = 1'b0;
    wr1      = 1'b0;
    off_next = off_e;
    lp_next  = lp_e;
    if (!halt) begin
      if (zbit && grow_e) begin
        // doubled column
        off_next = off_e + 12'd2;
        if (item.clear_pixel) begin
          lp_next = pos;
        end else begin
          lp_next = pos1;
          wr0     = ok0;
          wr1     = ok1;
        end
      end else if (!zbit) begin
        // plain column
        off_next = off_e + 12'd1;
        lp_next  = pos;
        wr0      = ok0 && !item.clear_pixel;
      end
    end
  end

  // Pack the writes, first result first
  always_comb begin
    new0.pixel_out    = item.color_value;
    new0.priority_out = prio_e;
    new1.pixel_out    = item.color_value;
    new1.priority_out = prio_e;
    new1.screen_x     = pos1[SX_W-1:0];
    new1.last_write   = 1'b1;
    new0.screen_x     = wr0 ? pos[SX_W-1:0] : pos1[SX_W-1:0];
    new0.last_write   = !(wr0 && wr1);
    n_res             = {1'b0, wr0} + {1'b0, wr1};
  end

  // Row state update
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index  <= '0;
      draw_offset   <= '0;
      last_draw_pos <= '0;
      row_start_x   <= '0;
      row_zoom      <= '0;
      row_grow      <= 1'b0;
      row_priority  <= 1'b0;
      row_finished  <= 1'b0;
    end else if (consume) begin
      row_start_x  <= start_e;
      row_zoom     <= zoom_e;
      row_grow     <= grow_e;
      row_priority <= prio_e;
      if (halt) begin
        column_index  <= col_e;
        draw_offset   <= off_e;
        last_draw_pos <= lp_e;
        row_finished  <= fin_e;
      end else begin
        column_index  <= col_e + 5'd1;
        draw_offset   <= off_next;
        last_draw_pos <= lp_next;
        row_finished  <= (lp_next == width_s);
      end
    end
  end

  // Result buffer, head in res0
  always_ff @(posedge clk) begin
    if (rst) begin
      res_count <= 2'd0;
    end else if (consume) begin
      res_count <= n_res;
    end else if (pop) begin
      res_count <= res_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      res0 <= new0;
      res1 <= new1;
    end else if (pop) begin
      res0 <= res1;
    end
  end

  assign dst.valid        = (res_count != 2'd0);
  assign dst.screen_x     = res0.screen_x;
  assign dst.pixel_out    = res0.pixel_out;
  assign dst.priority_out = res0.priority_out;
  assign dst.last_write   = res0.last_write;

`ifndef ASSERT_OFF
  // buffer never overfills
  a_count_max : assert property (@(posedge clk) disable iff (rst)
    res_count != 2'd3) else $error("result buffer overfilled");

  // a lone buffered write always closes its column
  a_last_head : assert property (@(posedge clk) disable iff (rst)
    res_count == 2'd1 |-> res0.last_write) else $error("lone write lacks last_write");

  // finished row emits nothing until a new row starts
  a_fin_quiet : assert property (@(posedge clk) disable iff (rst)
    (consume && row_finished && !item.first_column) |=> res_count == 2'd0)
    else $error("write after row finished");

  // output is empty on the first cycle out of reset
  a_rst_empty : assert property (@(posedge clk)
    ($past(rst) && !rst) |-> !dst.valid) else $error("output valid after reset");
`endif

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the zoomed sprite line scaler against a model of its behavior that
// runs inside this bench. Source columns are queued by the stimulus block
// and sent by a clocked driver. Each accepted column is scaled by the model
// into the line buffer writes it should cause. A clocked monitor compares
// every write the block produces with the oldest write the model expects.
// The line width register is changed only between phases, while the block
// is idle.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import zsl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  zsl_in_if  src_if ();
  zsl_out_if dst_if ();

  zoomed_sprite_line_scaler_top dut (
    .clk     (clk),
    .rst     (rst),
    .src     (src_if),
    .dst     (dst_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard storage
  item_t columns_to_send[$];
  item_t in_flight;
  res_t  pending_writes[$];
  int    idle_pct = 28;
  int    mismatches = 0;
  int    columns_accepted = 0;
  int    writes_checked = 0;
  int    widths_used = 0;
  int    cycle_count = 0;

  // Row model state
  logic [COL_W-1:0]  col_idx = '0;
  int                draw_off = 0;
  int                last_pos = 0;
  int                row_x = 0;
  logic [ZOOM_W-1:0] row_mask = '0;
  logic              row_grow = 1'b0;
  logic              row_prio = 1'b0;
  logic              row_done = 1'b0;
  int                line_width;

  // Clip one draw position to the screen and queue the write it gives
  function automatic void put_write(int pos, logic [PIX_W-1:0] pix);
    res_t w;
    if (pos < 0 || pos >= line_width || pos >= LINE_LIMIT) return;
    w.screen_x     = pos[SX_W-1:0];
    w.pixel_out    = pix;
    w.priority_out = row_prio;
    w.last_write   = 1'b0;
    pending_writes.push_back(w);
  endfunction

  // Scale one source column into its expected line buffer writes
  function automatic void scale_column(item_t c);
    int   pos;
    int   writes_prior;
    logic marked;
    res_t tail;
    writes_prior = pending_writes.size();
    if (c.first_column) begin
      row_x    = $signed(c.start_x);
      row_mask = c.zoom_mask;
      row_grow = c.grow;
      row_prio = c.priority_req;
      col_idx  = '0;
      draw_off = 0;
      last_pos = 0;
      row_done = 1'b0;
    end
    // finished or overlong rows swallow the column whole
    if (row_done || draw_off >= 2 * MAX_ROW_PIXELS) return;
    marked = row_mask[col_idx];
    pos = row_x + draw_off;
    if (marked && row_grow) begin
      // doubled column; a clear one still moves by two
      last_pos = pos;
      if (!c.clear_pixel) begin
        put_write(pos, c.color_value);
        put_write(pos + 1, c.color_value);
        last_pos = pos + 1;
      end
      draw_off += 2;
    end else if (!marked) begin
      last_pos = pos;
      if (!c.clear_pixel) put_write(pos, c.color_value);
      draw_off += 1;
    end
    col_idx = col_idx + 1'b1;
    if (last_pos == line_width) row_done = 1'b1;
    if (pending_writes.size() > writes_prior) begin
      tail = pending_writes.pop_back();
      tail.last_write = 1'b1;
      pending_writes.push_back(tail);
    end
  endfunction

  function automatic item_t column(logic first, int sx, logic [ZOOM_W-1:0] mask,
                                   logic grow, logic prio, logic clear, int color);
    item_t c;
    c.first_column = first;
    c.start_x      = sx[STARTX_W-1:0];
    c.zoom_mask    = mask;
    c.grow         = grow;
    c.priority_req = prio;
    c.clear_pixel  = clear;
    c.color_value  = color[PIX_W-1:0];
    return c;
  endfunction

  function automatic item_t rand_column(logic first);
    int                sx;
    logic [ZOOM_W-1:0] mask;
    case ($urandom_range(3))
      0:       sx = $urandom;
      default: sx = int'($urandom_range(1063)) - 40;
    endcase
    case ($urandom_range(4))
      0:       mask = '1;
      1:       mask = '0;
      2:       mask = ZOOM_W'(1) << $urandom_range(31);
      3:       mask = $urandom & $urandom;
      default: mask = $urandom;
    endcase
    return column(first, sx, mask, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom_range(3) == 0, $urandom_range(1023));
  endfunction

  // Mostly whole rows with random content, some stray columns between them
  task automatic queue_random_columns(int count);
    int added;
    int len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(99) < 12) begin
        columns_to_send.push_back(rand_column(1'b0));
        added++;
      end else begin
        len = ($urandom_range(4) == 0) ? $urandom_range(33, 70) : $urandom_range(1, 32);
        columns_to_send.push_back(rand_column(1'b1));
        for (int i = 1; i < len; i++) columns_to_send.push_back(rand_column(1'b0));
        added += len;
      end
    end
  endtask

  // Wait until the block has taken every column and produced every write
  task automatic drain;
    do @(negedge clk);
    while (columns_to_send.size() != 0 || src_if.valid || pending_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic set_line_width(int w);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * REG_SCREEN_WIDTH);
    pwdata  <= 32'(w);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    line_width = w & 32'h7ff;
    widths_used++;
  endtask

  task automatic note_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Column driver: scales each accepted column, then offers the next one
  always @(posedge clk) begin
    if (rst) begin
      src_if.valid        <= 1'b0;
      src_if.first_column <= 1'b0;
      src_if.start_x      <= '0;
      src_if.zoom_mask    <= '0;
      src_if.grow         <= 1'b0;
      src_if.priority_req <= 1'b0;
      src_if.clear_pixel  <= 1'b0;
      src_if.color_value  <= '0;
    end else begin
      if (src_if.valid && src_if.ready) begin
        scale_column(in_flight);
        columns_accepted++;
      end
      if (!src_if.valid || src_if.ready) begin
        if (columns_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_flight = columns_to_send.pop_front();
          src_if.first_column <= in_flight.first_column;
          src_if.start_x      <= in_flight.start_x;
          src_if.zoom_mask    <= in_flight.zoom_mask;
          src_if.grow         <= in_flight.grow;
          src_if.priority_req <= in_flight.priority_req;
          src_if.clear_pixel  <= in_flight.clear_pixel;
          src_if.color_value  <= in_flight.color_value;
          src_if.valid        <= 1'b1;
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // Line buffer side backpressure
  always @(posedge clk) begin
    if (rst) begin
      dst_if.ready <= 1'b0;
    end else begin
      dst_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Write monitor
  always @(posedge clk) begin
    res_t want;
    if (!rst && dst_if.valid && dst_if.ready) begin
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write x=%0d pix=%0d",
                                dst_if.screen_x, dst_if.pixel_out));
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (dst_if.screen_x !== want.screen_x)
          note_mismatch($sformatf("screen_x %0d, want %0d", dst_if.screen_x, want.screen_x));
        if (dst_if.pixel_out !== want.pixel_out)
          note_mismatch($sformatf("pixel_out %0d, want %0d at x=%0d",
                                  dst_if.pixel_out, want.pixel_out, want.screen_x));
        if (dst_if.priority_out !== want.priority_out)
          note_mismatch($sformatf("priority_out %0b, want %0b at x=%0d",
                                  dst_if.priority_out, want.priority_out, want.screen_x));
        if (dst_if.last_write !== want.last_write)
          note_mismatch($sformatf("last_write %0b, want %0b at x=%0d",
                                  dst_if.last_write, want.last_write, want.screen_x));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    line_width = int'(WIDTH_RESET);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: columns before any row, then edge rows at reset width
    columns_to_send.push_back(column(0, 0, '0, 0, 0, 0, 0));
    columns_to_send.push_back(column(0, 0, '0, 0, 0, 1, 1023));
    columns_to_send.push_back(column(1, -1024, '0, 0, 1, 0, 1023));
    columns_to_send.push_back(column(1, 10, '1, 1, 0, 0, 1023));
    columns_to_send.push_back(column(0, 0, '0, 0, 1, 1, 7));
    columns_to_send.push_back(column(0, 0, '0, 0, 1, 0, 'h155));
    columns_to_send.push_back(column(1, 20, 32'haaaa_aaaa, 0, 1, 0, 'h2aa));
    columns_to_send.push_back(column(0, 0, '0, 1, 0, 0, 'h155));
    columns_to_send.push_back(column(0, 0, '0, 1, 0, 0, 'h0f0));
    columns_to_send.push_back(column(0, 0, '0, 1, 0, 0, 'h30f));
    columns_to_send.push_back(column(1, 445, '0, 0, 1, 0, 1));
    columns_to_send.push_back(column(0, 0, '1, 1, 0, 0, 2));
    columns_to_send.push_back(column(0, 0, '1, 1, 0, 0, 3));
    columns_to_send.push_back(column(0, 0, '1, 1, 0, 0, 4));
    columns_to_send.push_back(column(0, 0, '1, 1, 0, 0, 5));
    columns_to_send.push_back(column(1, 1023, '0, 0, 0, 0, 6));
    columns_to_send.push_back(column(1, -2, 32'h8000_0001, 1, 1, 0, 'h3ff));
    columns_to_send.push_back(column(0, 0, '0, 0, 0, 0, 'h200));
    columns_to_send.push_back(column(0, 0, '0, 0, 0, 1, 'h100));
    columns_to_send.push_back(column(0, 0, '0, 0, 0, 0, 'h001));
    queue_random_columns(30);
    drain();
    // another random batch once the block has drained, same width
    queue_random_columns(20);
    drain();

    // full line, no idling on either side
    set_line_width(1024);
    idle_pct = 0;
    queue_random_columns(60);
    drain();
    idle_pct = 28;

    // width beyond the line buffer, plus one overlong row from the far left
    set_line_width(2047);
    columns_to_send.push_back(column(1, -1024, '1, 1, 1, 0, $urandom_range(1023)));
    for (int i = 0; i < 1026; i++)
      columns_to_send.push_back(column(0, $urandom, $urandom, 1'($urandom_range(1)),
                                       1'($urandom_range(1)), $urandom_range(7) == 0,
                                       $urandom_range(1023)));
    drain();

    set_line_width(0);
    queue_random_columns(20);
    drain();

    set_line_width(1);
    queue_random_columns(20);
    drain();

    set_line_width($urandom_range(1, 1024));
    queue_random_columns(20);
    drain();

    $display("Sent %0d columns over %0d width settings; %0d line buffer writes checked",
             columns_accepted, widths_used + 1, writes_checked);
    $display("Rows covered grow and shrink masks, clear pixels, clipping and an overlong row");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/zsl_pkg.sv
hdl/zsl_in_if.sv
hdl/zsl_out_if.sv
hdl/zoomed_sprite_line_scaler_top.sv
tb/sv/testbench.sv
